// File: hw/rtl/qcs_pkg.sv
// ----------------------------------------------------------------------------
// qcs_pkg: shared types of the quadratic curve subdivider
// Token tag carried along the cell chain, cell phase and emit sequencer
// states.
// ----------------------------------------------------------------------------
`default_nettype none

package qcs_pkg;

    // control part of a token moving between cells
    typedef struct packed {
        logic pt;    // token carries a point
        logic last;  // final token of the curve
    } qcs_tag_t;

    // where a cell stands within its current triple
    typedef enum logic [1:0] {
        PH_START,
        PH_MIDDLE,
        PH_END
    } qcs_phase_t;

    // emit sequencer of one cell
    typedef enum logic [2:0] {
        EM_IDLE,
        EM_ANCHOR,
        EM_M1,
        EM_MID,
        EM_M2,
        EM_C,
        EM_END
    } qcs_emit_t;

endpackage

`default_nettype wire

// File: hw/rtl/quadratic_curve_subdivider.sv
// ----------------------------------------------------------------------------
// quadratic_curve_subdivider: quadratic curve midpoint subdivision
// Control points enter on the s_axis side, one per word, tlast on the final
// point of a curve. ROUNDS cells in a row each split point triples into five
// points; the tail packs the resulting curve points into m_axis words.
// Each m_axis word holds up to two points (tuser = count); the first word of
// a curve holds only the start point, and tlast marks the curve's last word.
// A curve of fewer than three points gives one empty word (count 0, tlast).
// A cell takes a new point only while idle or as it sends the end point of a
// triple, not while it emits the other points of the triple. One input point
// expands to about 2**ROUNDS points at the output.
// Every cell and the packer end in a register, so a stalled m_axis side
// holds the chain back point by point and nothing is lost.
// Reset clears all cells and the packer; the next point starts a new curve.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_curve_subdivider #(
    parameter int ROUNDS     = 5,
    parameter int COORD_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // control point input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // x_coord[15:0], y_coord[31:16]
    input  wire logic        s_axis_tlast,   // end_of_curve
    // curve point output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // first_x, first_y, second_x, second_y
    output logic [1:0]       m_axis_tuser,   // point_count
    output logic             m_axis_tlast    // curve_done
);
    import qcs_pkg::*;

    logic                  lk_valid [ROUNDS+1];
    logic                  lk_ready [ROUNDS+1];
    logic [COORD_BITS-1:0] lk_x     [ROUNDS+1];
    logic [COORD_BITS-1:0] lk_y     [ROUNDS+1];
    qcs_tag_t              lk_tag   [ROUNDS+1];

    logic [15:0] first_x, first_y, second_x, second_y;

    // input word into the first link
    assign lk_valid[0]   = s_axis_tvalid;
    assign s_axis_tready = lk_ready[0];
    assign lk_x[0]       = COORD_BITS'(s_axis_tdata[15:0]);
    assign lk_y[0]       = COORD_BITS'(s_axis_tdata[31:16]);
    assign lk_tag[0]     = '{pt: 1'b1, last: s_axis_tlast};

    // row of subdivision cells
    for (genvar k = 0; k < ROUNDS; k++)
    begin : g_cell
        qcs_cell #(
            .CW (COORD_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (lk_valid[k]),
            .in_ready  (lk_ready[k]),
            .in_x      (lk_x[k]),
            .in_y      (lk_y[k]),
            .in_tag    (lk_tag[k]),
            .out_valid (lk_valid[k+1]),
            .out_ready (lk_ready[k+1]),
            .out_x     (lk_x[k+1]),
            .out_y     (lk_y[k+1]),
            .out_tag   (lk_tag[k+1])
        );
    end

    // pairing of points into output words
    qcs_pack #(
        .CW (COORD_BITS)
    ) u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (lk_valid[ROUNDS]),
        .in_ready    (lk_ready[ROUNDS]),
        .in_x        (lk_x[ROUNDS]),
        .in_y        (lk_y[ROUNDS]),
        .in_tag      (lk_tag[ROUNDS]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .first_x     (first_x),
        .first_y     (first_y),
        .second_x    (second_x),
        .second_y    (second_y),
        .point_count (m_axis_tuser),
        .curve_done  (m_axis_tlast)
    );

    assign m_axis_tdata = {second_y, second_x, first_y, first_x};

endmodule

`default_nettype wire

// File: hw/rtl/qcs_cell.sv
// ----------------------------------------------------------------------------
// qcs_cell: one subdivision round
// Collects point triples (a,b,c) sharing end points and emits
// a (first triple of a curve only), mid(a,b), mid of mids, mid(b,c), c
// one point per cycle to the next cell, unless the next cell stalls.
`default_nettype none

module qcs_cell #(
    parameter int CW = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // upstream side
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [CW-1:0]    in_x,
    input  wire logic [CW-1:0]    in_y,
    input  wire qcs_pkg::qcs_tag_t in_tag,
    // downstream side
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [CW-1:0]         out_x,
    output logic [CW-1:0]         out_y,
    output qcs_pkg::qcs_tag_t     out_tag
);
    import qcs_pkg::*;

    function automatic logic [CW-1:0] half_sum(input logic [CW-1:0] p, input logic [CW-1:0] q);
        logic [CW:0] s;
        s = {1'b0, p} + {1'b0, q};
        return s[CW:1];
    endfunction

    qcs_emit_t  state_reg, state_next;
    qcs_phase_t phase_reg, phase_next;
    logic       fresh_reg, fresh_next;

    logic [CW-1:0] anchor_x_reg, anchor_x_next, anchor_y_reg, anchor_y_next;
    logic [CW-1:0] middle_x_reg, middle_x_next, middle_y_reg, middle_y_next;

    // points of the triple being emitted
    logic [CW-1:0] ea_x_reg, ea_x_next, ea_y_reg, ea_y_next;
    logic [CW-1:0] m1_x_reg, m1_x_next, m1_y_reg, m1_y_next;
    logic [CW-1:0] m2_x_reg, m2_x_next, m2_y_reg, m2_y_next;
    logic [CW-1:0] c_x_reg, c_x_next, c_y_reg, c_y_next;
    logic          c_last_reg, c_last_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    qcs_tag_t      out_tag_reg, out_tag_next;

    logic          adv;
    logic          acc;
    logic [CW-1:0] emit_x, emit_y;
    qcs_tag_t      emit_tag;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EM_IDLE;
            phase_reg     <= PH_START;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        anchor_x_reg <= anchor_x_next;
        anchor_y_reg <= anchor_y_next;
        middle_x_reg <= middle_x_next;
        middle_y_reg <= middle_y_next;
        ea_x_reg     <= ea_x_next;
        ea_y_reg     <= ea_y_next;
        m1_x_reg     <= m1_x_next;
        m1_y_reg     <= m1_y_next;
        m2_x_reg     <= m2_x_next;
        m2_y_reg     <= m2_y_next;
        c_x_reg      <= c_x_next;
        c_y_reg      <= c_y_next;
        c_last_reg   <= c_last_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_tag_reg  <= out_tag_next;
    end

    // point presented by the sequencer
    always_comb
    begin
        emit_x   = c_x_reg;
        emit_y   = c_y_reg;
        emit_tag = '{pt: 1'b1, last: 1'b0};
        unique case (state_reg)
            EM_ANCHOR:
            begin
                emit_x = ea_x_reg;
                emit_y = ea_y_reg;
            end
            EM_M1:
            begin
                emit_x = m1_x_reg;
                emit_y = m1_y_reg;
            end
            EM_MID:
            begin
                emit_x = half_sum(m1_x_reg, m2_x_reg);
                emit_y = half_sum(m1_y_reg, m2_y_reg);
            end
            EM_M2:
            begin
                emit_x = m2_x_reg;
                emit_y = m2_y_reg;
            end
            EM_C:
            begin
                emit_tag = '{pt: 1'b1, last: c_last_reg};
            end
            EM_END:
            begin
                emit_x   = '0;
                emit_y   = '0;
                emit_tag = '{pt: 1'b0, last: 1'b1};
            end
            default:
            begin
                emit_tag = '{pt: 1'b1, last: 1'b0};
            end
        endcase
    end

    // sequencer, triple collection and output register
    always_comb
    begin
        adv      = (state_reg != EM_IDLE) && (!out_valid_reg || out_ready);
        in_ready = (state_reg == EM_IDLE) || ((state_reg == EM_C) && adv);
        acc      = in_valid && in_ready;

        state_next    = state_reg;
        phase_next    = phase_reg;
        fresh_next    = fresh_reg;
        anchor_x_next = anchor_x_reg;
        anchor_y_next = anchor_y_reg;
        middle_x_next = middle_x_reg;
        middle_y_next = middle_y_reg;
        ea_x_next     = ea_x_reg;
        ea_y_next     = ea_y_reg;
        m1_x_next     = m1_x_reg;
        m1_y_next     = m1_y_reg;
        m2_x_next     = m2_x_reg;
        m2_y_next     = m2_y_reg;
        c_x_next      = c_x_reg;
        c_y_next      = c_y_reg;
        c_last_next   = c_last_reg;

        // step through the emit sequence
        if (adv)
        begin
            unique case (state_reg)
                EM_ANCHOR: state_next = EM_M1;
                EM_M1:     state_next = EM_MID;
                EM_MID:    state_next = EM_M2;
                EM_M2:     state_next = EM_C;
                EM_C:      state_next = EM_IDLE;
                EM_END:    state_next = EM_IDLE;
                default:   state_next = EM_IDLE;
            endcase
        end

        // take a new token
        if (acc)
        begin
            if (!in_tag.pt)
            begin
                state_next = EM_END;
            end
            else
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        anchor_x_next = in_x;
                        anchor_y_next = in_y;
                        phase_next    = PH_MIDDLE;
                        if (in_tag.last)
                            state_next = EM_END;
                    end
                    PH_MIDDLE:
                    begin
                        middle_x_next = in_x;
                        middle_y_next = in_y;
                        phase_next    = PH_END;
                        if (in_tag.last)
                            state_next = EM_END;
                    end
                    default:
                    begin
                        ea_x_next     = anchor_x_reg;
                        ea_y_next     = anchor_y_reg;
                        m1_x_next     = half_sum(anchor_x_reg, middle_x_reg);
                        m1_y_next     = half_sum(anchor_y_reg, middle_y_reg);
                        m2_x_next     = half_sum(middle_x_reg, in_x);
                        m2_y_next     = half_sum(middle_y_reg, in_y);
                        c_x_next      = in_x;
                        c_y_next      = in_y;
                        c_last_next   = in_tag.last;
                        anchor_x_next = in_x;
                        anchor_y_next = in_y;
                        phase_next    = PH_MIDDLE;
                        fresh_next    = 1'b0;
                        state_next    = fresh_reg ? EM_ANCHOR : EM_M1;
                    end
                endcase
            end
            // end of curve returns the cell to its start
            if (in_tag.last)
            begin
                phase_next = PH_START;
                fresh_next = 1'b1;
            end
        end

        // output register
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_tag_next = out_tag_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_x_next     = emit_x;
            out_y_next     = emit_y;
            out_tag_next   = emit_tag;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_tag   = out_tag_reg;

endmodule

`default_nettype wire

// File: hw/rtl/qcs_pack.sv
// ----------------------------------------------------------------------------
// qcs_pack: output pairing of curve points
// Sends the start point of a curve alone, pairs later points two per word
// and closes each curve with a done flag or an empty end marker.
// ----------------------------------------------------------------------------
`default_nettype none

module qcs_pack #(
    parameter int CW = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // point stream from the last cell
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [CW-1:0]    in_x,
    input  wire logic [CW-1:0]    in_y,
    input  wire qcs_pkg::qcs_tag_t in_tag,
    // result words
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [15:0]           first_x,
    output logic [15:0]           first_y,
    output logic [15:0]           second_x,
    output logic [15:0]           second_y,
    output logic [1:0]            point_count,
    output logic                  curve_done
);
    import qcs_pkg::*;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    logic          start_sent_reg, start_sent_next;
    logic          held_valid_reg, held_valid_next;
    logic [CW-1:0] held_x_reg, held_x_next, held_y_reg, held_y_next;

    logic          out_valid_reg, out_valid_next;
    logic [15:0]   fx_reg, fx_next, fy_reg, fy_next;
    logic [15:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          done_reg, done_next;

    logic          acc;
    logic          emit;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_sent_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            start_sent_reg <= start_sent_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        held_x_reg <= held_x_next;
        held_y_reg <= held_y_next;
        fx_reg     <= fx_next;
        fy_reg     <= fy_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        cnt_reg    <= cnt_next;
        done_reg   <= done_next;
    end

    // pairing of points into words
    always_comb
    begin
        in_ready = !out_valid_reg || out_ready;
        acc      = in_valid && in_ready;

        start_sent_next = start_sent_reg;
        held_valid_next = held_valid_reg;
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        emit            = 1'b0;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        cnt_next        = cnt_reg;
        done_next       = done_reg;

        if (acc)
        begin
            done_next = in_tag.last;
            if (in_tag.pt && !start_sent_reg)
            begin
                // start point of the curve goes alone
                emit            = 1'b1;
                fx_next         = 16'(in_x);
                fy_next         = 16'(in_y);
                sx_next         = '0;
                sy_next         = '0;
                cnt_next        = CNT_ONE;
                start_sent_next = 1'b1;
            end
            else if (in_tag.pt && held_valid_reg)
            begin
                // complete a pair
                emit            = 1'b1;
                fx_next         = 16'(held_x_reg);
                fy_next         = 16'(held_y_reg);
                sx_next         = 16'(in_x);
                sy_next         = 16'(in_y);
                cnt_next        = CNT_TWO;
                held_valid_next = 1'b0;
            end
            else if (in_tag.pt)
            begin
                // wait for a partner, or flush alone at end of curve
                held_x_next     = in_x;
                held_y_next     = in_y;
                held_valid_next = 1'b1;
                if (in_tag.last)
                begin
                    emit     = 1'b1;
                    fx_next  = 16'(in_x);
                    fy_next  = 16'(in_y);
                    sx_next  = '0;
                    sy_next  = '0;
                    cnt_next = CNT_ONE;
                end
            end
            else if (held_valid_reg)
            begin
                // end with an unpaired point left over
                emit     = 1'b1;
                fx_next  = 16'(held_x_reg);
                fy_next  = 16'(held_y_reg);
                sx_next  = '0;
                sy_next  = '0;
                cnt_next = CNT_ONE;
            end
            else
            begin
                // end with nothing to send: empty marker
                emit     = 1'b1;
                fx_next  = '0;
                fy_next  = '0;
                sx_next  = '0;
                sy_next  = '0;
                cnt_next = CNT_NONE;
            end

            if (in_tag.last)
            begin
                start_sent_next = 1'b0;
                held_valid_next = 1'b0;
                held_x_next     = '0;
                held_y_next     = '0;
            end
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid   = out_valid_reg;
    assign first_x     = fx_reg;
    assign first_y     = fy_reg;
    assign second_x    = sx_reg;
    assign second_y    = sy_reg;
    assign point_count = cnt_reg;
    assign curve_done  = done_reg;

endmodule

`default_nettype wire

// File: test/quadratic_curve_subdivider_tb.sv
// ----------------------------------------------------------------------------
// quadratic_curve_subdivider_tb: self-checking bench of the curve subdivider
// Streams control point curves into the block, predicts every output word
// with a behavioral copy of the five-stage midpoint split and the pair
// packer, and checks each m_axis word in order against that prediction.
// Both sides idle at random; a long receiver stall backs the chain up.
// ----------------------------------------------------------------------------

module quadratic_curve_subdivider_tb;

    import qcs_pkg::*;

    localparam int ROUNDS       = 5;
    localparam int MAX_WORDS    = 33;
    localparam int DRAIN_CYCLES = 50;
    localparam int RANDOM_ITEMS = 156;
    localparam int HOLD_START   = 800;
    localparam int HOLD_CYCLES  = 600;
    localparam int QUIET_FROM   = 3000;
    localparam int QUIET_TO     = 6000;

    // one control point as the sender sees it
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
    } control_point_t;

    // one output word, fields as carried on m_axis
    typedef struct packed {
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [1:0]  cnt;
        logic        done;
    } curve_word_t;

    // pending split of one point into one stage
    typedef struct packed {
        logic [3:0]  stage;
        logic [15:0] x;
        logic [15:0] y;
    } cut_job_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    control_point_t pending_points [$];
    curve_word_t    curve_words [$];
    curve_word_t    step_words [$];
    cut_job_t       cut_jobs [$];

    // predictor state
    logic [15:0] cut_first_x [ROUNDS] = '{default: '0};
    logic [15:0] cut_first_y [ROUNDS] = '{default: '0};
    logic [15:0] cut_mid_x [ROUNDS] = '{default: '0};
    logic [15:0] cut_mid_y [ROUNDS] = '{default: '0};
    qcs_phase_t  cut_phase [ROUNDS] = '{default: PH_START};
    logic [15:0] pend_x = '0;
    logic [15:0] pend_y = '0;
    logic        pend_ok = 1'b0;
    logic        head_sent = 1'b0;

    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    int unsigned points_taken = 0;
    int unsigned curves_taken = 0;
    int unsigned words_checked = 0;
    int unsigned mismatches = 0;
    control_point_t point_next;

    wire quiet_stretch = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    quadratic_curve_subdivider dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // x_coord[15:0], y_coord[31:16]
        .s_axis_tlast  (s_axis_tlast),   // end_of_curve
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // first_x, first_y, second_x, second_y
        .m_axis_tuser  (m_axis_tuser),   // point_count
        .m_axis_tlast  (m_axis_tlast)    // curve_done
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // truncating midpoint of two coordinates
    function automatic logic [15:0] halve_sum(logic [15:0] p, logic [15:0] q);
        logic [16:0] s;
        s = {1'b0, p} + {1'b0, q};
        return s[16:1];
    endfunction

    function automatic void push_word(logic [15:0] fx, logic [15:0] fy,
                                      logic [15:0] sx, logic [15:0] sy,
                                      logic [1:0] cnt);
        if (step_words.size() < MAX_WORDS)
            step_words.insert(step_words.size(),
                              '{fx: fx, fy: fy, sx: sx, sy: sy, cnt: cnt, done: 1'b0});
    endfunction

    // pair up points leaving the last stage, start point goes alone
    function automatic void pack_curve_point(logic [15:0] x, logic [15:0] y);
        if (!head_sent)
        begin
            push_word(x, y, '0, '0, 2'd1);
            head_sent = 1'b1;
        end
        else if (pend_ok)
        begin
            push_word(pend_x, pend_y, x, y, 2'd2);
            pend_ok = 1'b0;
        end
        else
        begin
            pend_x = x;
            pend_y = y;
            pend_ok = 1'b1;
        end
    endfunction

    // depth-first walk of the stage cascade, jobs kept on a stack
    function automatic void split_through_stages(logic [15:0] x, logic [15:0] y);
        cut_job_t    j;
        int          k;
        logic        first;
        logic [15:0] ax, ay, m1x, m1y, m2x, m2y;
        cut_jobs.delete();
        cut_jobs.insert(cut_jobs.size(), '{stage: 4'd0, x: x, y: y});
        while (cut_jobs.size() != 0)
        begin
            j = cut_jobs.pop_back();
            k = int'(j.stage);
            if (k >= ROUNDS)
            begin
                pack_curve_point(j.x, j.y);
            end
            else if (cut_phase[k] == PH_START)
            begin
                cut_first_x[k] = j.x;
                cut_first_y[k] = j.y;
                cut_phase[k] = PH_MIDDLE;
            end
            else if (cut_phase[k] == PH_MIDDLE)
            begin
                cut_mid_x[k] = j.x;
                cut_mid_y[k] = j.y;
                cut_phase[k] = PH_END;
            end
            else
            begin
                first = (k + 1 < ROUNDS) ? (cut_phase[k + 1] == PH_START) : !head_sent;
                ax = cut_first_x[k];
                ay = cut_first_y[k];
                m1x = halve_sum(ax, cut_mid_x[k]);
                m1y = halve_sum(ay, cut_mid_y[k]);
                m2x = halve_sum(cut_mid_x[k], j.x);
                m2y = halve_sum(cut_mid_y[k], j.y);
                cut_first_x[k] = j.x;
                cut_first_y[k] = j.y;
                cut_phase[k] = PH_MIDDLE;
                // pushed in reverse so the next stage sees them in order
                cut_jobs.insert(cut_jobs.size(), '{stage: 4'(k + 1), x: j.x, y: j.y});
                cut_jobs.insert(cut_jobs.size(), '{stage: 4'(k + 1), x: m2x, y: m2y});
                cut_jobs.insert(cut_jobs.size(), '{stage: 4'(k + 1),
                                                   x: halve_sum(m1x, m2x),
                                                   y: halve_sum(m1y, m2y)});
                cut_jobs.insert(cut_jobs.size(), '{stage: 4'(k + 1), x: m1x, y: m1y});
                if (first)
                    cut_jobs.insert(cut_jobs.size(), '{stage: 4'(k + 1), x: ax, y: ay});
            end
        end
    endfunction

    // expected words caused by one accepted control point
    function automatic void predict_curve_step(logic [15:0] x, logic [15:0] y,
                                               logic last);
        curve_word_t w;
        step_words.delete();
        split_through_stages(x, y);
        if (last)
        begin
            if (pend_ok)
            begin
                push_word(pend_x, pend_y, '0, '0, 2'd1);
                pend_ok = 1'b0;
            end
            // end step with nothing to send gives an empty end marker
            if (step_words.size() == 0)
                push_word('0, '0, '0, '0, 2'd0);
            w = step_words.pop_back();
            w.done = 1'b1;
            step_words.insert(step_words.size(), w);
            for (int k = 0; k < ROUNDS; k++)
                cut_phase[k] = PH_START;
            pend_x = '0;
            pend_y = '0;
            head_sent = 1'b0;
        end
        foreach (step_words[i])
            curve_words.insert(curve_words.size(), step_words[i]);
    endfunction

    function automatic logic [15:0] rand_coord();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom());
    endfunction

    function automatic void add_point(logic [15:0] x, logic [15:0] y, logic last);
        pending_points.insert(pending_points.size(), '{x: x, y: y, last: last});
    endfunction

    function automatic void add_random_curve(int n);
        for (int i = 0; i < n; i++)
            add_point(rand_coord(), rand_coord(), i == n - 1);
    endfunction

    // driver: offers the next pending point, holds it until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_points.size() != 0 &&
                (quiet_stretch || $urandom_range(0, 99) >= 9))
            begin
                point_next = pending_points.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {point_next.y, point_next.x};
                s_axis_tlast  <= point_next.last;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver stall, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && cycle_count == HOLD_START)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left != 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= quiet_stretch || ($urandom_range(0, 99) >= 9);
    end

    // monitor: check output words, then predict from the accepted input
    always @(posedge clk)
    begin : watch_streams
        curve_word_t got;
        curve_word_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{fx: m_axis_tdata[15:0], fy: m_axis_tdata[31:16],
                        sx: m_axis_tdata[47:32], sy: m_axis_tdata[63:48],
                        cnt: m_axis_tuser, done: m_axis_tlast};
                if (curve_words.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected word: x0 %h y0 %h x1 %h y1 %h count %0d done %b",
                                 got.fx, got.fy, got.sx, got.sy, got.cnt, got.done);
                end
                else
                begin
                    want = curve_words.pop_front();
                    if (got != want)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                        begin
                            $display("word %0d mismatch", words_checked);
                            $display("  expected x0 %h y0 %h x1 %h y1 %h count %0d done %b",
                                     want.fx, want.fy, want.sx, want.sy, want.cnt, want.done);
                            $display("  actual   x0 %h y0 %h x1 %h y1 %h count %0d done %b",
                                     got.fx, got.fy, got.sx, got.sy, got.cnt, got.done);
                        end
                    end
                    words_checked = words_checked + 1;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_curve_step(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
                points_taken = points_taken + 1;
                if (s_axis_tlast)
                    curves_taken = curves_taken + 1;
            end
        end
    end

    // stimulus and end of run
    initial
    begin : run_curves
        int queued;
        int n;
        // single point and two point curves give only an end marker
        add_point(16'h1234, 16'h8765, 1'b1);
        add_point(16'h0000, 16'hFFFF, 1'b0);
        add_point(16'hFFFF, 16'h0000, 1'b1);
        // one triple at the extremes
        add_point(16'h0000, 16'h0000, 1'b0);
        add_point(16'hFFFF, 16'hFFFF, 1'b0);
        add_point(16'h0000, 16'h0000, 1'b1);
        // four points: trailing point dropped in the first stage
        add_point(16'hFFFF, 16'h0000, 1'b0);
        add_point(16'h0000, 16'hFFFF, 1'b0);
        add_point(16'hFFFF, 16'h0000, 1'b0);
        add_point(16'h8000, 16'h7FFF, 1'b1);
        // five points at full scale
        for (int i = 0; i < 5; i++)
            add_point(16'hFFFF, 16'hFFFF, i == 4);
        // all zero triple
        for (int i = 0; i < 3; i++)
            add_point(16'h0000, 16'h0000, i == 2);
        // alternating bit patterns, six points
        for (int i = 0; i < 6; i++)
            add_point(i[0] ? 16'h5555 : 16'hAAAA, i[0] ? 16'hAAAA : 16'h5555, i == 5);
        // random curves, mostly long enough to reach the last stage
        queued = 0;
        while (queued < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 12)
                n = $urandom_range(1, 2);
            else
                n = $urandom_range(3, 11);
            add_random_curve(n);
            queued = queued + n;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_points.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (curve_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d control points in %0d curves, %0d output words checked",
                 points_taken, curves_taken, words_checked);
        $display("with random idling on both sides and a %0d cycle receiver stall",
                 HOLD_CYCLES);
        if (mismatches == 0 && curve_words.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #8000000;
        $display("timeout with %0d words still expected", curve_words.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/qcs_pkg.sv
hw/rtl/qcs_cell.sv
hw/rtl/qcs_pack.sv
hw/rtl/quadratic_curve_subdivider.sv
test/quadratic_curve_subdivider_tb.sv
